### design/cfm_pkg.sv
// shared types and constants for the capture frequency meter
package cfm_pkg;

    // field widths
    localparam int unsigned CaptureW = 16;
    localparam int unsigned PeriodW  = 17;
    localparam int unsigned ClockW   = 27;
    localparam int unsigned CountW   = 16;

    // divider step count, one quotient bit per step
    localparam int unsigned DivSteps = ClockW;
    localparam int unsigned StepW    = $clog2(DivSteps);

    // reset value of the clock frequency register
    localparam logic [ClockW-1:0] ClockReset = ClockW'(8000000);

    // event source codes
    typedef enum logic {
        CMD_CAPTURE = 1'b0,
        CMD_OTHER   = 1'b1
    } cmd_t;

    // sequencer states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DIVIDE = 3'b010,
        ST_WRITE  = 3'b100
    } state_t;

    // divider request from the sequencer
    typedef struct packed {
        logic              start;
        logic [ClockW-1:0]  dividend;
        logic [PeriodW-1:0] divisor;
    } div_req_t;

    // divider status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### design/capture_frequency_meter_unit.sv
// capture frequency meter: period, frequency, pulse count and indicator per capture
// a capture beat is accepted, runs 27 divider steps, hands the quotient over and loads the
// output register; no new beat is taken until that load
// a non-capture beat leaves the sequencer idle, a zero period skips the divider; s_tready stays low until the result
// is loaded, so m_tready back-pressure also stalls the input; reset: synchronous, active low,
// clears counts, previous capture and indicator, loads 8000000 into the clock register
module capture_frequency_meter_unit
    import cfm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write: clock_hz
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [26:0] cfg_data,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] capture_value, [16] rolled_over, [23:17] zero
    input  logic [0:0]  s_tuser,   // [0] cmd
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [16:0] period_ticks, [43:17] frequency_hz,
                                   // [59:44] pulse_total, [60] indicator, [63:61] zero
    output logic [0:0]  m_tuser    // [0] zero_period
);

    state_t              state_reg, state_next;
    logic [ClockW-1:0]   clock_reg;
    logic [CaptureW-1:0] prev_reg;
    logic [CountW-1:0]   pulse_reg;
    logic                ind_reg;
    logic [PeriodW-1:0]  period_reg;
    logic                zero_reg;

    logic                m_valid_reg, m_valid_next;
    logic [63:0]         m_data_reg;
    logic                m_zero_reg;

    logic                s_accept;
    logic                capture;
    logic [CaptureW-1:0] cur;
    logic [PeriodW-1:0]  period;
    logic                out_free;
    logic                load_out;

    div_req_t            div_req;
    div_stat_t           div_stat;
    logic [ClockW-1:0]   quotient;

    // handshakes
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign capture   = s_accept && (cmd_t'(s_tuser[0]) == CMD_CAPTURE);
    assign cur       = s_tdata[CaptureW-1:0];
    assign out_free  = !m_valid_reg || m_tready;
    assign load_out  = (state_reg == ST_WRITE) && out_free;

    // period between this capture and the previous one
    always_comb begin
        if (s_tdata[16]) begin
            period = {1'b1, cur} - {1'b0, prev_reg};
        end else begin
            period = {1'b0, cur - prev_reg};
        end
    end

    // divider request
    assign div_req.start    = capture && (period != '0);
    assign div_req.dividend = clock_reg;
    assign div_req.divisor  = period;

    cfm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (capture) begin
                    state_next = (period == '0) ? ST_WRITE : ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (div_stat.done) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // output register valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            clock_reg   <= ClockReset;
            prev_reg    <= '0;
            pulse_reg   <= '0;
            ind_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                clock_reg <= cfg_data;
            end
            if (capture) begin
                prev_reg  <= cur;
                pulse_reg <= pulse_reg + 1'b1;
                ind_reg   <= ~ind_reg;
            end
        end
    end

    // per-capture payload
    always_ff @(posedge aclk) begin
        if (capture) begin
            period_reg <= period;
            zero_reg   <= (period == '0);
        end
        if (load_out) begin
            m_data_reg <= {3'b000, ind_reg, pulse_reg,
                           zero_reg ? '0 : quotient, period_reg};
            m_zero_reg <= zero_reg;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_zero_reg;

    // divider only runs in the divide state
    a_busy_in_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.busy |-> (state_reg == ST_DIVIDE))
        else $error("divider busy outside divide state");

    // zero period skips the divider
    a_zero_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        (capture && (period == '0)) |=> (state_reg == ST_WRITE) && !div_stat.busy)
        else $error("zero period did not skip the divider");

    // each capture advances the pulse count by one
    a_pulse_step: assert property (@(posedge aclk) disable iff (!aresetn)
        capture |=> (pulse_reg == $past(pulse_reg) + 1'b1))
        else $error("pulse count did not advance");

    // a loaded result is presented on the next cycle
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> m_valid_reg)
        else $error("loaded result not valid");

endmodule

### design/cfm_div.sv
// iterative restoring divider, one quotient bit per cycle
module cfm_div
    import cfm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  div_req_t           req,
    output div_stat_t          stat,
    output logic [ClockW-1:0]  quotient
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [StepW-1:0]    count_reg, count_next;
    logic [PeriodW-1:0]  rem_reg, rem_next;
    logic [ClockW-1:0]   quo_reg, quo_next;
    logic [PeriodW-1:0]  dsr_reg, dsr_next;

    logic [PeriodW:0]    trial;
    logic [PeriodW:0]    diff;

    // trial subtract of the shifted partial remainder
    assign trial = {rem_reg, quo_reg[ClockW-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    // step control
    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dsr_next   = dsr_reg;
        if (req.start) begin
            busy_next  = 1'b1;
            count_next = StepW'(DivSteps - 1);
            rem_next   = '0;
            quo_next   = req.dividend;
            dsr_next   = req.divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = diff[PeriodW-1:0];
                quo_next = {quo_reg[ClockW-2:0], 1'b1};
            end else begin
                rem_next = trial[PeriodW-1:0];
                quo_next = {quo_reg[ClockW-2:0], 1'b0};
            end
            if (count_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        count_reg <= count_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        dsr_reg   <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

    // a new division never starts over a running one
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    // done follows the last step
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

    // remainder stays below the divisor while running
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (rem_reg < dsr_reg))
        else $error("partial remainder out of range");

endmodule

### sim/testbench.sv
// self-checking testbench for the capture frequency meter unit
module testbench
    import cfm_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // one measurement as it leaves the block
    typedef struct packed {
        logic [PeriodW-1:0] period;
        logic [ClockW-1:0]  freq;
        logic [CountW-1:0]  pulses;
        logic               lamp;
        logic               zero;
    } capture_meas_t;

    // one row of the directed stimulus, with an optional hand-typed answer
    typedef struct packed {
        cmd_t                cmd;
        logic [CaptureW-1:0] cap;
        logic                roll;
        logic                typed;
        capture_meas_t       want;
    } stim_row_t;

    localparam int unsigned SettleCycles = 40;
    localparam int unsigned RandomPerPhase = 270;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [26:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // [15:0] capture_value, [16] rolled_over, [23:17] zero
    logic [0:0]  s_tuser = '0;   // [0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;        // [16:0] period_ticks, [43:17] frequency_hz,
                                 // [59:44] pulse_total, [60] indicator, [63:61] zero
    logic [0:0]  m_tuser;        // [0] zero_period

    // meter state as the block should hold it
    logic [ClockW-1:0]   meter_clock_hz = ClockReset;
    logic [CaptureW-1:0] last_capture = '0;
    logic [CountW-1:0]   pulse_tally = '0;
    logic                lamp_level = 1'b0;

    capture_meas_t awaited_meas [$];
    stim_row_t     plan [$];
    int unsigned   mismatch_count = 0;
    bit            src_calm = 1'b0;
    bit            sink_calm = 1'b0;

    capture_frequency_meter_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // clock
    initial begin
        forever #10 aclk = ~aclk;
    end

    // run limit
    initial begin
        #20ms;
        $display("capture_frequency_meter_unit verification failed");
        $finish;
    end

    // next capture measurement, advancing the meter state
    function automatic capture_meas_t measure_capture(logic [CaptureW-1:0] cap, logic roll);
        capture_meas_t m;
        pulse_tally = pulse_tally + 1'b1;
        lamp_level  = ~lamp_level;
        if (roll) begin
            m.period = 17'h10000 + {1'b0, cap} - {1'b0, last_capture};
        end else begin
            m.period = {1'b0, cap - last_capture};
        end
        m.zero   = (m.period == '0);
        m.freq   = m.zero ? '0 : ClockW'(meter_clock_hz / m.period);
        m.pulses = pulse_tally;
        m.lamp   = lamp_level;
        last_capture = cap;
        return m;
    endfunction

    function automatic stim_row_t make_row(cmd_t c, logic [15:0] cap, logic roll, logic typed,
                                           logic [16:0] p, logic [26:0] f, logic [15:0] n,
                                           logic lamp, logic z);
        stim_row_t r;
        r.cmd  = c;
        r.cap  = cap;
        r.roll = roll;
        r.typed = typed;
        r.want = '{period: p, freq: f, pulses: n, lamp: lamp, zero: z};
        return r;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int unsigned pick_idle(bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    // drive one event beat; a capture's expectation is queued once the beat is taken
    task automatic push_beat(cmd_t c, logic [15:0] cap, logic roll, logic typed,
                             capture_meas_t want);
        int unsigned gap;
        capture_meas_t m;
        if ($urandom_range(0, 99) < 2) src_calm = !src_calm;
        gap = pick_idle(src_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, roll, cap};
        s_tuser  <= c;
        do @(posedge aclk); while (!s_tready);
        if (c == CMD_CAPTURE) begin
            m = measure_capture(cap, roll);
            awaited_meas.push_back(typed ? want : m);
        end
    endtask

    // clock register write, only once the block has drained
    task automatic write_clock(logic [ClockW-1:0] hz);
        s_tvalid <= 1'b0;
        wait (awaited_meas.size() == 0);
        repeat (SettleCycles) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= hz;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        meter_clock_hz = hz;
    endtask

    task automatic compare_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // result side: random back-pressure and field-by-field check
    initial begin
        int unsigned hold;
        capture_meas_t w;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                if (awaited_meas.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result beat with nothing expected, actual %h", $time,
                             m_tdata);
                end else begin
                    w = awaited_meas.pop_front();
                    compare_field("period_ticks", w.period, m_tdata[16:0]);
                    compare_field("frequency_hz", w.freq, m_tdata[43:17]);
                    compare_field("pulse_total", w.pulses, m_tdata[59:44]);
                    compare_field("indicator", w.lamp, m_tdata[60]);
                    compare_field("zero_period", w.zero, m_tuser[0]);
                end
            end
            if ($urandom_range(0, 99) < 2) sink_calm = !sink_calm;
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                hold = pick_idle(sink_calm);
                m_tready <= (hold == 0);
            end
        end
    end

    // stimulus
    initial begin
        logic [ClockW-1:0] clock_plan [$];
        capture_meas_t     none;
        int unsigned       r;
        logic [16:0]       delta;
        logic [16:0]       sum;
        logic              roll;
        none = '0;

        // directed rows at the reset clock of 8 MHz
        plan = '{
            // first capture after reset: zero period
            make_row(CMD_CAPTURE, 16'h0000, 1'b0, 1'b1, 17'd0, 27'd0, 16'd1, 1'b1, 1'b1),
            // other event source: ignored
            make_row(CMD_OTHER, 16'hFFFF, 1'b1, 1'b0, '0, '0, '0, 1'b0, 1'b0),
            make_row(CMD_CAPTURE, 16'd1000, 1'b0, 1'b1, 17'd1000, 27'd8000, 16'd2, 1'b0, 1'b0),
            make_row(CMD_CAPTURE, 16'hFFFF, 1'b0, 1'b1, 17'd64535, 27'd123, 16'd3, 1'b1, 1'b0),
            make_row(CMD_CAPTURE, 16'hFFFF, 1'b1, 1'b1, 17'd65536, 27'd122, 16'd4, 1'b0, 1'b0),
            // shortest period gives the full clock
            make_row(CMD_CAPTURE, 16'h0000, 1'b1, 1'b1, 17'd1, 27'd8000000, 16'd5, 1'b1, 1'b0),
            make_row(CMD_CAPTURE, 16'h0000, 1'b1, 1'b1, 17'd65536, 27'd122, 16'd6, 1'b0, 1'b0),
            make_row(CMD_CAPTURE, 16'h0000, 1'b0, 1'b1, 17'd0, 27'd0, 16'd7, 1'b1, 1'b1),
            // longest period
            make_row(CMD_CAPTURE, 16'hFFFF, 1'b1, 1'b1, 17'd131071, 27'd61, 16'd8, 1'b0, 1'b0),
            make_row(CMD_CAPTURE, 16'hFFFE, 1'b1, 1'b0, '0, '0, '0, 1'b0, 1'b0),
            make_row(CMD_CAPTURE, 16'h0001, 1'b0, 1'b0, '0, '0, '0, 1'b0, 1'b0),
            make_row(CMD_OTHER, 16'h0000, 1'b0, 1'b0, '0, '0, '0, 1'b0, 1'b0),
            make_row(CMD_CAPTURE, 16'h5555, 1'b1, 1'b0, '0, '0, '0, 1'b0, 1'b0),
            make_row(CMD_CAPTURE, 16'hAAAA, 1'b0, 1'b0, '0, '0, '0, 1'b0, 1'b0),
            make_row(CMD_CAPTURE, 16'hAAAA, 1'b1, 1'b0, '0, '0, '0, 1'b0, 1'b0),
            make_row(CMD_OTHER, 16'hAAAA, 1'b1, 1'b0, '0, '0, '0, 1'b0, 1'b0),
            make_row(CMD_CAPTURE, 16'h8000, 1'b0, 1'b0, '0, '0, '0, 1'b0, 1'b0),
            make_row(CMD_CAPTURE, 16'h7FFF, 1'b0, 1'b0, '0, '0, '0, 1'b0, 1'b0),
            make_row(CMD_CAPTURE, 16'h7FFF, 1'b0, 1'b0, '0, '0, '0, 1'b0, 1'b0),
            make_row(CMD_CAPTURE, 16'h0003, 1'b0, 1'b0, '0, '0, '0, 1'b0, 1'b0)
        };

        // clock settings: range ends, zero and all ones, then random, then the reset value
        clock_plan = '{27'd100000000, 27'd1, 27'd0, 27'h7FFFFFF,
                       ClockW'($urandom_range(1, 100000000)),
                       ClockW'($urandom_range(1, 1000)), ClockReset};

        // reset
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            push_beat(plan[i].cmd, plan[i].cap, plan[i].roll, plan[i].typed, plan[i].want);
        end

        // random phases, one clock setting each
        foreach (clock_plan[p]) begin
            write_clock(clock_plan[p]);
            for (int unsigned n = 0; n < RandomPerPhase; n++) begin
                r = $urandom_range(0, 99);
                if (r < 12) begin
                    push_beat(CMD_OTHER, 16'($urandom), 1'($urandom), 1'b0, none);
                end else begin
                    // captures follow the last one by a step of chosen scale
                    case ($urandom_range(0, 9))
                        0:       delta = '0;
                        1, 2, 3: delta = 17'($urandom_range(1, 64));
                        4, 5:    delta = 17'($urandom_range(65, 4096));
                        6, 7, 8: delta = 17'($urandom_range(0, 65535));
                        default: delta = 17'($urandom_range(65536, 131071));
                    endcase
                    sum  = {1'b0, last_capture} + delta;
                    roll = sum[16] | delta[16];
                    // occasional inconsistent overflow flag
                    if ($urandom_range(0, 9) == 0) roll = ~roll;
                    push_beat(CMD_CAPTURE, sum[15:0], roll, 1'b0, none);
                end
            end
        end
        s_tvalid <= 1'b0;

        // drain and let any stray result show up
        wait (awaited_meas.size() == 0);
        repeat (SettleCycles) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("capture_frequency_meter_unit verification clean");
        end else begin
            $display("capture_frequency_meter_unit verification failed");
        end
        $finish;
    end

endmodule
